### hw/rtl/t3rcd_pkg.sv
// Shared types and constants for the T3 record coincidence detector.
// Holds the record field layout, the event and result structs used between stages.
// No dependencies.
`timescale 1ns / 1ps

package t3rcd_pkg;

    localparam int RECORD_W   = 32;
    localparam int SYNC_W     = 10;
    localparam int DELAY_W    = 15;
    localparam int CHAN_W     = 6;
    localparam int TIME_W     = 64;
    localparam int COUNT_W    = 32;
    localparam int WINDOW_W   = 10;
    localparam int WRAP_SHIFT = 10;

    // Record field positions.
    localparam int SYNC_LSB    = 0;
    localparam int DELAY_LSB   = 10;
    localparam int CHAN_LSB    = 25;
    localparam int SPECIAL_BIT = 31;

    localparam logic [CHAN_W-1:0]   OVERFLOW_CHANNEL = 6'h3F;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET     = 10'd1;

    // Decoded signal or idler event on its way to the coincidence stage.
    typedef struct packed {
        logic               valid;
        logic               chan;
        logic [TIME_W-1:0]  sync_time;
        logic [DELAY_W-1:0] delay;
    } event_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic               event_channel;
        logic [TIME_W-1:0]  sync_time;
        logic [DELAY_W-1:0] delay_time;
        logic               is_coincidence;
        logic [TIME_W-1:0]  partner_sync;
        logic [DELAY_W-1:0] partner_delay;
        logic [COUNT_W-1:0] signal_total;
        logic [COUNT_W-1:0] idler_total;
        logic [COUNT_W-1:0] coinc_total;
    } result_t;

endpackage

### hw/rtl/t3_record_coincidence_detector_unit.sv
// Top level of the T3 record coincidence detector.
// Holds the window register and connects t3rcd_decode and t3rcd_coinc; uses t3rcd_pkg.
`timescale 1ns / 1ps

// Usage:
// Raw 32-bit T3 records enter on the s_ channel (s_valid, s_ready, s_record_word).
// Each record is one request. Overflow records advance an internal 64-bit sync
// offset; markers, other special records and ordinary records on channels above 1
// are consumed silently. Each signal (channel 0) or idler (channel 1) event yields
// exactly one result request on the m_ channel with its absolute sync time, delay,
// coincidence flag, the partner channel's last event and the running totals.
// An accepted record is first held in the decode register and is then loaded into
// the result register, which drives m_valid.
// Throughput: one record per cycle while m_ready is high; the decode stage takes a
// new record while a finished result is still waiting on the output. The two 64-bit
// adds of the decode stage and the 64-bit subtract and window compare of the
// coincidence stage each sit between their own registers and set the clock.
// When the receiver holds m_ready low, the result register and then the decode
// register fill, and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous) clears the offset, last events, seen flags,
// all counters and both valid flags, and sets coinc_window to 1.
// cfg_wr_en writes cfg_wr_data into coinc_window on the same edge; write it only
// while no request is in flight.

module t3_record_coincidence_detector_unit
    import t3rcd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [WINDOW_W-1:0] cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [RECORD_W-1:0] s_record_word,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_event_channel,
    output logic [TIME_W-1:0]   m_sync_time,
    output logic [DELAY_W-1:0]  m_delay_time,
    output logic                m_is_coincidence,
    output logic [TIME_W-1:0]   m_partner_sync,
    output logic [DELAY_W-1:0]  m_partner_delay,
    output logic [COUNT_W-1:0]  m_signal_total,
    output logic [COUNT_W-1:0]  m_idler_total,
    output logic [COUNT_W-1:0]  m_coinc_total
);

    // Coincidence window in syncs; written directly from the configuration port.
    logic [WINDOW_W-1:0] window_reg;

    // Decoded event between the two stages, and the take strobe going back.
    event_t  ev;
    logic    ev_take;
    result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    // Stage one: record split, overflow offset and absolute sync time.
    t3rcd_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_record_word (s_record_word),
        .ev_take       (ev_take),
        .ev            (ev)
    );

    // Stage two: partner lookup, window check, counters and result register.
    t3rcd_coinc u_coinc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ev           (ev),
        .ev_take      (ev_take),
        .coinc_window (window_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .res          (res)
    );

    assign m_event_channel  = res.event_channel;
    assign m_sync_time      = res.sync_time;
    assign m_delay_time     = res.delay_time;
    assign m_is_coincidence = res.is_coincidence;
    assign m_partner_sync   = res.partner_sync;
    assign m_partner_delay  = res.partner_delay;
    assign m_signal_total   = res.signal_total;
    assign m_idler_total    = res.idler_total;
    assign m_coinc_total    = res.coinc_total;

endmodule

### hw/rtl/t3rcd_decode.sv
// Record decode stage: splits T3 records, keeps the overflow offset and
// registers signal and idler events with their absolute sync time. Uses t3rcd_pkg.
`timescale 1ns / 1ps

module t3rcd_decode
    import t3rcd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [RECORD_W-1:0] s_record_word,
    input  logic                ev_take,
    output event_t              ev
);

    logic [SYNC_W-1:0]  nsync;
    logic [DELAY_W-1:0] delay;
    logic [CHAN_W-1:0]  chan;
    logic               special;
    logic               accept;
    logic               is_overflow;
    logic               is_event;
    logic [SYNC_W-1:0]  mult;
    logic [TIME_W-1:0]  step;

    logic [TIME_W-1:0]  offset_reg;
    logic [TIME_W-1:0]  offset_next;
    logic               ev_valid_reg;
    logic               ev_valid_next;
    logic               ev_chan_reg;
    logic [TIME_W-1:0]  ev_sync_reg;
    logic [DELAY_W-1:0] ev_delay_reg;

    assign nsync   = s_record_word[SYNC_LSB +: SYNC_W];
    assign delay   = s_record_word[DELAY_LSB +: DELAY_W];
    assign chan    = s_record_word[CHAN_LSB +: CHAN_W];
    assign special = s_record_word[SPECIAL_BIT];

    assign s_ready = !ev_valid_reg || ev_take;
    assign accept  = s_valid && s_ready;

    assign is_overflow = special && (chan == OVERFLOW_CHANNEL);
    assign is_event    = !special && (chan[CHAN_W-1:1] == '0);

    // An overflow record with a zero sync field counts as one wrap.
    assign mult = (nsync == '0) ? SYNC_W'(1) : nsync;
    assign step = {{(TIME_W-SYNC_W-WRAP_SHIFT){1'b0}}, mult, {WRAP_SHIFT{1'b0}}};

    assign offset_next = offset_reg + step;

    always_comb begin
        ev_valid_next = ev_valid_reg;
        if (accept) begin
            ev_valid_next = is_event;
        end else if (ev_take) begin
            ev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            ev_valid_reg <= ev_valid_next;
            if (accept && is_overflow) begin
                offset_reg <= offset_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_event) begin
            ev_chan_reg  <= chan[0];
            ev_sync_reg  <= offset_reg + {{(TIME_W-SYNC_W){1'b0}}, nsync};
            ev_delay_reg <= delay;
        end
    end

    assign ev.valid     = ev_valid_reg;
    assign ev.chan      = ev_chan_reg;
    assign ev.sync_time = ev_sync_reg;
    assign ev.delay     = ev_delay_reg;

endmodule

### hw/rtl/t3rcd_coinc.sv
// Coincidence stage: keeps per-channel last event, seen flags and counters,
// and loads the result register. Uses t3rcd_pkg.
`timescale 1ns / 1ps

module t3rcd_coinc
    import t3rcd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  event_t              ev,
    output logic                ev_take,
    input  logic [WINDOW_W-1:0] coinc_window,
    output logic                m_valid,
    input  logic                m_ready,
    output result_t             res
);

    logic               is_signal;
    logic [TIME_W-1:0]  psync;
    logic [DELAY_W-1:0] pdelay;
    logic               pseen;
    logic [TIME_W-1:0]  diff;
    logic               in_window;
    logic               coinc;

    logic [TIME_W-1:0]  sig_sync_reg;
    logic [DELAY_W-1:0] sig_delay_reg;
    logic               sig_seen_reg;
    logic [TIME_W-1:0]  idl_sync_reg;
    logic [DELAY_W-1:0] idl_delay_reg;
    logic               idl_seen_reg;
    logic [COUNT_W-1:0] sig_cnt_reg;
    logic [COUNT_W-1:0] sig_cnt_next;
    logic [COUNT_W-1:0] idl_cnt_reg;
    logic [COUNT_W-1:0] idl_cnt_next;
    logic [COUNT_W-1:0] coinc_cnt_reg;
    logic [COUNT_W-1:0] coinc_cnt_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    result_t            res_reg;

    assign ev_take   = ev.valid && (!m_valid_reg || m_ready);
    assign is_signal = !ev.chan;

    assign psync  = is_signal ? idl_sync_reg  : sig_sync_reg;
    assign pdelay = is_signal ? idl_delay_reg : sig_delay_reg;
    assign pseen  = is_signal ? idl_seen_reg  : sig_seen_reg;

    // Wrapping difference, compared against the window.
    assign diff      = ev.sync_time - psync;
    assign in_window = (diff[TIME_W-1:WINDOW_W] == '0) && (diff[WINDOW_W-1:0] <= coinc_window);
    assign coinc     = pseen && in_window;

    assign sig_cnt_next   = sig_cnt_reg + {{(COUNT_W-1){1'b0}}, is_signal};
    assign idl_cnt_next   = idl_cnt_reg + {{(COUNT_W-1){1'b0}}, !is_signal};
    assign coinc_cnt_next = coinc_cnt_reg + {{(COUNT_W-1){1'b0}}, coinc};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ev_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_sync_reg  <= '0;
            sig_delay_reg <= '0;
            sig_seen_reg  <= 1'b0;
            idl_sync_reg  <= '0;
            idl_delay_reg <= '0;
            idl_seen_reg  <= 1'b0;
            sig_cnt_reg   <= '0;
            idl_cnt_reg   <= '0;
            coinc_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (ev_take) begin
                sig_cnt_reg   <= sig_cnt_next;
                idl_cnt_reg   <= idl_cnt_next;
                coinc_cnt_reg <= coinc_cnt_next;
                if (is_signal) begin
                    sig_sync_reg  <= ev.sync_time;
                    sig_delay_reg <= ev.delay;
                    sig_seen_reg  <= 1'b1;
                end else begin
                    idl_sync_reg  <= ev.sync_time;
                    idl_delay_reg <= ev.delay;
                    idl_seen_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_take) begin
            res_reg.event_channel  <= ev.chan;
            res_reg.sync_time      <= ev.sync_time;
            res_reg.delay_time     <= ev.delay;
            res_reg.is_coincidence <= coinc;
            res_reg.partner_sync   <= psync;
            res_reg.partner_delay  <= pdelay;
            res_reg.signal_total   <= sig_cnt_next;
            res_reg.idler_total    <= idl_cnt_next;
            res_reg.coinc_total    <= coinc_cnt_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

    // Every event taken bumps exactly one of the two channel counters.
    a_one_count_per_event: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_take |=> COUNT_W'(sig_cnt_reg + idl_cnt_reg)
                    == COUNT_W'($past(sig_cnt_reg + idl_cnt_reg) + COUNT_W'(1)))
        else $error("channel counters did not advance by one event");

    // A coincidence can only be flagged against a channel that has seen an event.
    a_coinc_needs_partner: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_take && !pseen) |=> !res_reg.is_coincidence)
        else $error("coincidence flagged without a partner event");

    // The coincidence counter moves only when a coincidence is loaded.
    a_coinc_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (coinc_cnt_reg != $past(coinc_cnt_reg)) |-> ($past(ev_take) && res_reg.is_coincidence))
        else $error("coincidence counter moved without a coincidence");

    // A pending event is not dropped while the result register is stalled.
    a_event_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev.valid && !ev_take) |=> ev.valid)
        else $error("pending event lost during stall");

endmodule
